// ===== rtl/rllt_pkg.sv =====
package rllt_pkg;

    // fixed field widths of the item and result beats and of the run length
    localparam int IDX_BITS  = 16;
    localparam int LINE_IO_BITS = 16;
    localparam int LEN_BITS  = 16;

    // longest run a single entry can hold
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // item modes
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        logic                    mode;
        logic [LINE_IO_BITS-1:0] line_number;
        logic [IDX_BITS-1:0]     instr_index;
    } item_t;

    typedef struct packed {
        status_t                 status;
        logic [LINE_IO_BITS-1:0] line_out;
    } result_t;

    // write strobes towards the run store
    typedef struct packed {
        logic line_we;
        logic len_we;
    } wr_ctl_t;

endpackage

// ===== rtl/rllt_stream_if.sv =====
interface rllt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/run_length_line_table.sv =====
// channel  | dir | payload                              | beat when
// item     | in  | mode, line_number, instr_index       | valid && ready
// result   | out | status, line_out                     | valid && ready
//
// a record beat needs no read: the last run is shadowed in registers, so
// extending or appending needs only a write to the run store
// a lookup walks the runs in order through the single read port of the run
// store, one run per cycle, until a run holds the index or all used runs are read
// reset clears the run count and the control state only; the run store has no clearing pass
// an item is taken only while idle and the result register is empty or draining
module run_length_line_table
    import rllt_pkg::*;
#(
    parameter int MAX_RUNS  = 256,
    parameter int LINE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rllt_stream_if.sink          item,
    rllt_stream_if.source        result
);

    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [CW-1:0]          addr_reg, addr_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LINE_BITS-1:0]   last_line_reg, last_line_next;
    logic [LEN_BITS-1:0]    last_len_reg, last_len_next;
    logic [LINE_IO_BITS-1:0] start_reg, start_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    status_t                out_status_reg;
    logic [LINE_IO_BITS-1:0] out_line_reg;

    logic                   item_fire;
    logic                   load_out;
    status_t                status_d;
    logic [LINE_IO_BITS-1:0] line_d;
    logic [LINE_BITS-1:0]   line_in;
    logic                   can_extend;
    logic                   table_full;
    logic [CW-1:0]          used_dec;
    logic                   issue;
    logic [LINE_IO_BITS:0]  run_end;
    logic                   hit;

    wr_ctl_t                wr_ctl;
    logic [AW-1:0]          wr_addr;
    logic [LEN_BITS-1:0]    wr_len;
    logic                   rd_en;
    logic [LINE_BITS-1:0]   rd_line;
    logic [LEN_BITS-1:0]    rd_len;

    rllt_run_store #(
        .DEPTH     (MAX_RUNS),
        .LINE_BITS (LINE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_ctl  (wr_ctl),
        .wr_addr (wr_addr),
        .wr_line (line_in),
        .wr_len  (wr_len),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_line (rd_line),
        .rd_len  (rd_len)
    );

    // handshake
    assign item.ready     = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign item_fire      = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = '{status: out_status_reg, line_out: out_line_reg};

    // record decision against the shadowed last run
    assign line_in    = LINE_BITS'(item.payload.line_number);
    assign used_dec   = used_reg - 1'b1;
    assign can_extend = (used_reg != '0) && (last_line_reg == line_in)
                        && (last_len_reg != LEN_MAX);
    assign table_full = (used_reg == CW'(MAX_RUNS));

    // walk datapath: an issue check, and one adder and one compare on the run just read
    assign issue   = (addr_reg < used_reg);
    assign run_end = {1'b0, start_reg} + {1'b0, rd_len};
    assign hit     = ({1'b0, idx_reg} < run_end);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        last_line_next = last_line_reg;
        last_len_next  = last_len_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        load_out       = 1'b0;
        status_d       = ST_OK;
        line_d         = '0;
        wr_ctl         = '0;
        wr_addr        = '0;
        wr_len         = '0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.payload.mode == MODE_LOOKUP)
                    begin
                        state_next = S_WALK;
                        idx_next   = item.payload.instr_index;
                        start_next = '0;
                        addr_next  = '0;
                    end
                    else
                    begin
                        load_out = 1'b1;
                        priority if (can_extend)
                        begin
                            wr_ctl.len_we = 1'b1;
                            wr_addr       = used_dec[AW-1:0];
                            wr_len        = last_len_reg + 1'b1;
                            last_len_next = last_len_reg + 1'b1;
                        end
                        else if (table_full)
                        begin
                            status_d = ST_FULL;
                        end
                        else
                        begin
                            wr_ctl.line_we = 1'b1;
                            wr_ctl.len_we  = 1'b1;
                            wr_addr        = used_reg[AW-1:0];
                            wr_len         = LEN_BITS'(1);
                            last_line_next = line_in;
                            last_len_next  = LEN_BITS'(1);
                            used_next      = used_reg + 1'b1;
                        end
                    end
                end
            end
            S_WALK:
            begin
                rd_en     = issue;
                pend_next = issue;
                addr_next = addr_reg + {{(CW-1){1'b0}}, issue};
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        load_out   = 1'b1;
                        line_d     = LINE_IO_BITS'(rd_line);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // no hit means the run ends at or below the index
                        start_next = run_end[LINE_IO_BITS-1:0];
                    end
                end
                else if (!issue)
                begin
                    load_out   = 1'b1;
                    status_d   = ST_MISS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_line_reg <= last_line_next;
        last_len_reg  <= last_len_next;
        start_reg     <= start_next;
        idx_reg       <= idx_next;
        if (load_out)
        begin
            out_status_reg <= status_d;
            out_line_reg   <= line_d;
        end
    end

    // run count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_RUNS))
        else $error("run count beyond table size");

    // the result register is empty for the whole walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !out_valid_reg)
        else $error("result pending during lookup walk");

    // a miss or a dropped record result carries no line
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_MISS || out_status_reg == ST_FULL))
        |-> (out_line_reg == '0))
        else $error("line on a result without a hit");

    // a full drop leaves the run count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.payload.mode == MODE_RECORD && !can_extend && table_full)
        |=> $stable(used_reg))
        else $error("run count moved on a dropped record");

endmodule

// ===== rtl/rllt_run_store.sv =====
module rllt_run_store
    import rllt_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int LINE_BITS = 16
) (
    input  logic                         clk,
    input  wr_ctl_t                      wr_ctl,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [LINE_BITS-1:0]         wr_line,
    input  logic [LEN_BITS-1:0]          wr_len,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [LINE_BITS-1:0]         rd_line,
    output logic [LEN_BITS-1:0]          rd_len
);

    logic [LINE_BITS-1:0] line_mem [DEPTH];
    logic [LEN_BITS-1:0]  len_mem  [DEPTH];

    // line column: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_ctl.line_we)
        begin
            line_mem[wr_addr] <= wr_line;
        end
        if (rd_en)
        begin
            rd_line <= line_mem[rd_addr];
        end
    end

    // length column
    always_ff @(posedge clk)
    begin
        if (wr_ctl.len_we)
        begin
            len_mem[wr_addr] <= wr_len;
        end
        if (rd_en)
        begin
            rd_len <= len_mem[rd_addr];
        end
    end

endmodule
